// File: sv/triangle_normal_unit_edges_unit_macros.svh
// assertion macros for the triangle normal unit
// used by the port checker; no other dependencies
`ifndef TRIANGLE_NORMAL_UNIT_EDGES_UNIT_MACROS_SVH
`define TRIANGLE_NORMAL_UNIT_EDGES_UNIT_MACROS_SVH

// same-cycle implication, masked during reset
`define TNEU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tneu port check failed");

// next-cycle implication, masked during reset
`define TNEU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tneu port check failed");

// next-cycle implication that also holds through reset
`define TNEU_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("tneu reset check failed");

`endif

// File: sv/tneu_pkg.sv
// shared widths and pipeline bus types of the triangle normal unit
// no dependencies
package tneu_pkg;

    localparam int NW     = 31;  // normalized edge magnitude
    localparam int SQ_W   = 64;  // sum of squares
    localparam int ROOT_W = 32;  // integer square root
    localparam int SREM_W = 33;  // square root remainder
    localparam int QW     = 31;  // quotient bits
    localparam int DREM_W = 32;  // divider remainder
    localparam int NUM_W  = 62;  // dividend

    // one edge moving through the square root chain
    typedef struct packed {
        logic                   valid;
        logic [SQ_W-1:0]        x;
        logic [SREM_W-1:0]      rem;
        logic [ROOT_W-1:0]      root;
        logic [2:0][NW-1:0]     m;
        logic [2:0]             neg;
        logic                   zero;
    } t_sqrt_bus;

    // one component moving through the divider chain
    typedef struct packed {
        logic                   valid;
        logic [DREM_W-1:0]      rem;
        logic [QW-1:0]          low;
        logic [QW-1:0]          quo;
        logic [ROOT_W-1:0]      norm;
        logic                   neg;
        logic                   zero;
    } t_div_bus;

endpackage

// File: sv/tneu_sqrt_cell.sv
// one root bit of the integer square root chain
// depends on tneu_pkg
module tneu_sqrt_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  tneu_pkg::t_sqrt_bus  i_bus,
    output tneu_pkg::t_sqrt_bus  o_bus
);

    tneu_pkg::t_sqrt_bus r_bus, n_bus;
    logic [tneu_pkg::SREM_W+1:0] w_acc, w_trial;

    // bring down two bits, try subtracting 4*root+1
    always_comb begin
        n_bus   = i_bus;
        w_acc   = {i_bus.rem, i_bus.x[tneu_pkg::SQ_W-1 -: 2]};
        w_trial = {1'b0, i_bus.root, 2'b01};
        n_bus.x = {i_bus.x[tneu_pkg::SQ_W-3:0], 2'b00};
        if (w_acc >= w_trial) begin
            n_bus.rem  = tneu_pkg::SREM_W'(w_acc - w_trial);
            n_bus.root = {i_bus.root[tneu_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            n_bus.rem  = w_acc[tneu_pkg::SREM_W-1:0];
            n_bus.root = {i_bus.root[tneu_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else if (i_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

// File: sv/tneu_div_cell.sv
// one quotient bit of the restoring divider chain
// depends on tneu_pkg
module tneu_div_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  tneu_pkg::t_div_bus  i_bus,
    output tneu_pkg::t_div_bus  o_bus
);

    tneu_pkg::t_div_bus r_bus, n_bus;
    logic [tneu_pkg::DREM_W:0] w_acc, w_den;
    logic                      w_bit;

    // shift in the next dividend bit and compare against the norm
    always_comb begin
        n_bus = i_bus;
        w_acc = {i_bus.rem, i_bus.low[tneu_pkg::QW-1]};
        w_den = {1'b0, i_bus.norm};
        w_bit = (w_acc >= w_den);
        if (w_bit) begin
            n_bus.rem = tneu_pkg::DREM_W'(w_acc - w_den);
        end else begin
            n_bus.rem = w_acc[tneu_pkg::DREM_W-1:0];
        end
        n_bus.low = {i_bus.low[tneu_pkg::QW-2:0], 1'b0};
        n_bus.quo = {i_bus.quo[tneu_pkg::QW-2:0], w_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else if (i_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

// File: sv/triangle_normal_unit_edges_unit.sv
// triangle normal from unit edges, computed by a fully registered pipeline from input request to result
// throughput one request per cycle; the whole pipeline stalls only while a result waits
// the 32-cell square root chain and 31-cell divider chains set the depth
// reset clears every stage valid bit; payload registers are not reset
// depends on tneu_pkg, tneu_sqrt_cell, tneu_div_cell
module triangle_normal_unit_edges_unit #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_p0_x,
    input  logic signed [COORD_WIDTH-1:0] i_p0_y,
    input  logic signed [COORD_WIDTH-1:0] i_p0_z,
    input  logic signed [COORD_WIDTH-1:0] i_p1_x,
    input  logic signed [COORD_WIDTH-1:0] i_p1_y,
    input  logic signed [COORD_WIDTH-1:0] i_p1_z,
    input  logic signed [COORD_WIDTH-1:0] i_p2_x,
    input  logic signed [COORD_WIDTH-1:0] i_p2_y,
    input  logic signed [COORD_WIDTH-1:0] i_p2_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [31:0]            o_normal_x,
    output logic signed [31:0]            o_normal_y,
    output logic signed [31:0]            o_normal_z
);

    localparam int MW  = COORD_WIDTH + 1;
    localparam int PW  = $clog2(MW);
    localparam int LW  = MW + tneu_pkg::NW;
    localparam int NSQ = tneu_pkg::ROOT_W;
    localparam int NDV = tneu_pkg::QW;
    localparam logic [tneu_pkg::QW-1:0] ONE_Q30 = {1'b1, {(tneu_pkg::QW-1){1'b0}}};

    logic w_en;
    logic signed [COORD_WIDTH-1:0] w_pt [3][3];

    logic                          r1_v, r2_v, r3_v, r4_v, r_c1_v, r_c2_v, r_out_v;
    logic [MW-1:0]                 r1_m [2][3], n1_m [2][3], r2_m [2][3];
    logic                          r1_neg [2][3], n1_neg [2][3], r2_neg [2][3];
    logic [PW-1:0]                 r2_pos [2], n2_pos [2];
    logic                          r2_zero [2], n2_zero [2];
    logic [tneu_pkg::NW-1:0]       r3_m [2][3], n3_m [2][3], r4_m [2][3];
    logic                          r3_neg [2][3], r4_neg [2][3];
    logic                          r3_zero [2], r4_zero [2];
    logic [2*tneu_pkg::NW-1:0]     r4_sq [2][3];

    tneu_pkg::t_sqrt_bus           r_sb0 [2], n_sb0 [2];
    tneu_pkg::t_sqrt_bus           w_sb [2][NSQ+1];
    tneu_pkg::t_div_bus            r_db0 [6], n_db0 [6];
    tneu_pkg::t_div_bus            w_db [6][NDV+1];

    logic signed [31:0]            r_q [6], n_q [6];
    logic signed [63:0]            r_prod [6];
    logic signed [31:0]            r_out_x, r_out_y, r_out_z;

    // whole pipe moves unless a finished result is held
    assign w_en    = !r_out_v || i_ready;
    assign o_ready = w_en;

    assign w_pt[0][0] = i_p0_x;
    assign w_pt[0][1] = i_p0_y;
    assign w_pt[0][2] = i_p0_z;
    assign w_pt[1][0] = i_p1_x;
    assign w_pt[1][1] = i_p1_y;
    assign w_pt[1][2] = i_p1_z;
    assign w_pt[2][0] = i_p2_x;
    assign w_pt[2][1] = i_p2_y;
    assign w_pt[2][2] = i_p2_z;

    // edge components as sign and magnitude
    always_comb begin
        logic signed [MW-1:0] w_d;
        for (int e = 0; e < 2; e++) begin
            for (int j = 0; j < 3; j++) begin
                w_d = {w_pt[e][j][COORD_WIDTH-1], w_pt[e][j]}
                    - {w_pt[2][j][COORD_WIDTH-1], w_pt[2][j]};
                n1_neg[e][j] = w_d[MW-1];
                n1_m[e][j]   = w_d[MW-1] ? MW'(-w_d) : MW'(w_d);
            end
        end
    end

    // leading one of the largest magnitude
    always_comb begin
        logic [MW-1:0] w_or;
        for (int e = 0; e < 2; e++) begin
            w_or      = r1_m[e][0] | r1_m[e][1] | r1_m[e][2];
            n2_zero[e] = (w_or == '0);
            n2_pos[e]  = '0;
            for (int i = 0; i < MW; i++) begin
                if (w_or[i]) begin
                    n2_pos[e] = PW'(i);
                end
            end
        end
    end

    // common shift so the largest lands in [2^30, 2^31)
    always_comb begin
        logic [LW-1:0] w_wide;
        for (int e = 0; e < 2; e++) begin
            for (int j = 0; j < 3; j++) begin
                w_wide = LW'(r2_m[e][j]);
                if (r2_pos[e] >= PW'(tneu_pkg::NW - 1)) begin
                    w_wide = w_wide >> (r2_pos[e] - PW'(tneu_pkg::NW - 1));
                end else begin
                    w_wide = w_wide << (PW'(tneu_pkg::NW - 1) - r2_pos[e]);
                end
                n3_m[e][j] = w_wide[tneu_pkg::NW-1:0];
            end
        end
    end

    // sum of squares loads the square root chain
    always_comb begin
        for (int e = 0; e < 2; e++) begin
            n_sb0[e].valid = r4_v;
            n_sb0[e].x     = tneu_pkg::SQ_W'(r4_sq[e][0]) + tneu_pkg::SQ_W'(r4_sq[e][1])
                           + tneu_pkg::SQ_W'(r4_sq[e][2]);
            n_sb0[e].rem   = '0;
            n_sb0[e].root  = '0;
            n_sb0[e].zero  = r4_zero[e];
            for (int j = 0; j < 3; j++) begin
                n_sb0[e].m[j]   = r4_m[e][j];
                n_sb0[e].neg[j] = r4_neg[e][j];
            end
        end
    end

    // front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v     <= 1'b0;
            r2_v     <= 1'b0;
            r3_v     <= 1'b0;
            r4_v     <= 1'b0;
            r_sb0[0].valid <= 1'b0;
            r_sb0[1].valid <= 1'b0;
        end else if (w_en) begin
            r1_v  <= i_valid;
            r2_v  <= r1_v;
            r3_v  <= r2_v;
            r4_v  <= r3_v;
            r_sb0 <= n_sb0;
            for (int e = 0; e < 2; e++) begin
                r2_pos[e]  <= n2_pos[e];
                r2_zero[e] <= n2_zero[e];
                r3_zero[e] <= r2_zero[e];
                r4_zero[e] <= r3_zero[e];
                for (int j = 0; j < 3; j++) begin
                    r1_m[e][j]   <= n1_m[e][j];
                    r1_neg[e][j] <= n1_neg[e][j];
                    r2_m[e][j]   <= r1_m[e][j];
                    r2_neg[e][j] <= r1_neg[e][j];
                    r3_m[e][j]   <= n3_m[e][j];
                    r3_neg[e][j] <= r2_neg[e][j];
                    r4_m[e][j]   <= r3_m[e][j];
                    r4_neg[e][j] <= r3_neg[e][j];
                    r4_sq[e][j]  <= r3_m[e][j] * r3_m[e][j];
                end
            end
        end
    end

    // square root chains, one per edge
    for (genvar e = 0; e < 2; e++) begin : g_sqrt
        assign w_sb[e][0] = r_sb0[e];
        for (genvar k = 0; k < NSQ; k++) begin : g_cell
            tneu_sqrt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_bus   (w_sb[e][k]),
                .o_bus   (w_sb[e][k+1])
            );
        end
    end

    // dividend m*2^30 + norm/2 for every component
    always_comb begin
        logic [tneu_pkg::NUM_W-1:0] w_num;
        for (int e = 0; e < 2; e++) begin
            for (int j = 0; j < 3; j++) begin
                w_num = {1'b0, w_sb[e][NSQ].m[j], {(tneu_pkg::NUM_W-tneu_pkg::NW-1){1'b0}}}
                      + tneu_pkg::NUM_W'(w_sb[e][NSQ].root >> 1);
                n_db0[e*3+j].valid = w_sb[e][NSQ].valid;
                n_db0[e*3+j].rem   = tneu_pkg::DREM_W'(w_num[tneu_pkg::NUM_W-1:tneu_pkg::QW]);
                n_db0[e*3+j].low   = w_num[tneu_pkg::QW-1:0];
                n_db0[e*3+j].quo   = '0;
                n_db0[e*3+j].norm  = w_sb[e][NSQ].root;
                n_db0[e*3+j].neg   = w_sb[e][NSQ].neg[j];
                n_db0[e*3+j].zero  = w_sb[e][NSQ].zero;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_db0[i].valid <= 1'b0;
            end
        end else if (w_en) begin
            r_db0 <= n_db0;
        end
    end

    // divider chains, one per edge component
    for (genvar i = 0; i < 6; i++) begin : g_div
        assign w_db[i][0] = r_db0[i];
        for (genvar k = 0; k < NDV; k++) begin : g_cell
            tneu_div_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_bus   (w_db[i][k]),
                .o_bus   (w_db[i][k+1])
            );
        end
    end

    // cap at one, apply sign, zero-length edge gives zero
    always_comb begin
        logic [tneu_pkg::QW-1:0] w_cap;
        for (int i = 0; i < 6; i++) begin
            w_cap = (w_db[i][NDV].quo > ONE_Q30) ? ONE_Q30 : w_db[i][NDV].quo;
            if (w_db[i][NDV].zero) begin
                n_q[i] = '0;
            end else if (w_db[i][NDV].neg) begin
                n_q[i] = -$signed({1'b0, w_cap});
            end else begin
                n_q[i] = $signed({1'b0, w_cap});
            end
        end
    end

    // round half away from zero to Q1.30 and saturate
    function automatic logic signed [31:0] round_sat(input logic signed [63:0] c);
        logic [63:0] mag;
        logic [33:0] rnd;
        logic signed [31:0] res;
        mag = c[63] ? 64'(-c) : 64'(c);
        rnd = 34'((mag + 64'(1 << 29)) >> 30);
        if (c[63]) begin
            res = (rnd > 34'(1) << 31) ? 32'sh8000_0000 : 32'(-$signed(rnd));
        end else begin
            res = (rnd > 34'h0_7fff_ffff) ? 32'sh7fff_ffff : 32'(rnd);
        end
        return res;
    endfunction

    // unit components, products, differences
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_v  <= 1'b0;
            r_c2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_c1_v  <= w_db[0][NDV].valid;
            r_c2_v  <= r_c1_v;
            r_out_v <= r_c2_v;
            r_q     <= n_q;
            r_prod[0] <= r_q[1] * r_q[5];
            r_prod[1] <= r_q[2] * r_q[4];
            r_prod[2] <= r_q[2] * r_q[3];
            r_prod[3] <= r_q[0] * r_q[5];
            r_prod[4] <= r_q[0] * r_q[4];
            r_prod[5] <= r_q[1] * r_q[3];
            r_out_x <= round_sat(r_prod[0] - r_prod[1]);
            r_out_y <= round_sat(r_prod[2] - r_prod[3]);
            r_out_z <= round_sat(r_prod[4] - r_prod[5]);
        end
    end

    assign o_valid    = r_out_v;
    assign o_normal_x = r_out_x;
    assign o_normal_y = r_out_y;
    assign o_normal_z = r_out_z;

endmodule

// File: sv/tneu_checker.sv
// port-level checks of the triangle normal unit, bound to the top level
// depends on triangle_normal_unit_edges_unit_macros.svh
`include "triangle_normal_unit_edges_unit_macros.svh"

module tneu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [31:0] o_normal_x,
    input logic signed [31:0] o_normal_y,
    input logic signed [31:0] o_normal_z
);

    logic w_stall;

    // result offered but not taken
    assign w_stall = o_valid && !i_ready;

    // nothing comes out right after reset
    `TNEU_ASSERT_RST(a_reset_idle, !i_rst_n, !o_valid)

    // a held result stays put
    `TNEU_ASSERT_NEXT(a_hold, w_stall, o_valid && $stable({o_normal_x, o_normal_y, o_normal_z}))

    // a stalled result back-pressures the input
    `TNEU_ASSERT_NOW(a_backpress, w_stall, !o_ready)

    // an empty output stage never refuses a request
    `TNEU_ASSERT_NOW(a_ready_idle, !o_valid, o_ready)

endmodule

bind triangle_normal_unit_edges_unit tneu_checker u_tneu_checker (.*);

// File: sim/tb_triangle_normal_unit_edges_unit.sv
// self-checking testbench for triangle_normal_unit_edges_unit
// predicts the cross product of unit triangle edges and checks each result in order
// depends only on the triangle_normal_unit_edges_unit rtl
module tb_triangle_normal_unit_edges_unit;

    localparam int CW = 32;
    localparam int LATENCY = 72;

    typedef struct {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
    } t_normal;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [CW-1:0] i_p0_x = '0, i_p0_y = '0, i_p0_z = '0;
    logic signed [CW-1:0] i_p1_x = '0, i_p1_y = '0, i_p1_z = '0;
    logic signed [CW-1:0] i_p2_x = '0, i_p2_y = '0, i_p2_z = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [31:0] o_normal_x, o_normal_y, o_normal_z;

    t_normal normal_queue[$];
    int errors = 0;
    int sent = 0;
    int checked = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    always #4 i_clk = ~i_clk;

    triangle_normal_unit_edges_unit #(.COORD_WIDTH(CW)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_p0_x(i_p0_x), .i_p0_y(i_p0_y), .i_p0_z(i_p0_z),
        .i_p1_x(i_p1_x), .i_p1_y(i_p1_y), .i_p1_z(i_p1_z),
        .i_p2_x(i_p2_x), .i_p2_y(i_p2_y), .i_p2_z(i_p2_z),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_normal_x(o_normal_x), .o_normal_y(o_normal_y), .o_normal_z(o_normal_z)
    );

    // integer square root of a 64-bit value
    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // scale one edge to unit length, q1.30 components
    function automatic void unit_edge(input longint d[3], output longint u[3]);
        logic [63:0] m[3];
        logic [63:0] mx, sum, norm, q;
        logic ng[3];
        int rs, ls;
        mx = 0;
        sum = 0;
        rs = 0;
        ls = 0;
        for (int j = 0; j < 3; j++) begin
            ng[j] = d[j] < 0;
            m[j] = ng[j] ? -d[j] : d[j];
            if (m[j] > mx) mx = m[j];
        end
        if (mx == 0) begin
            u[0] = 0; u[1] = 0; u[2] = 0;
            return;
        end
        while ((mx >> rs) >= (64'd1 << 31)) rs++;
        while ((mx << ls) < (64'd1 << 30)) ls++;
        for (int j = 0; j < 3; j++) begin
            m[j] = (m[j] >> rs) << ls;
            sum += m[j] * m[j];
        end
        norm = isqrt(sum);
        for (int j = 0; j < 3; j++) begin
            q = ((m[j] << 30) + (norm >> 1)) / norm;
            if (q > (64'd1 << 30)) q = 64'd1 << 30;
            u[j] = ng[j] ? -longint'(q) : longint'(q);
        end
    endfunction

    // round q2.60 to q1.30, halves away from zero, saturate
    function automatic logic signed [31:0] round_q30(input longint c);
        logic [63:0] mag;
        mag = (c < 0) ? -c : c;
        mag = (mag + (64'd1 << 29)) >> 30;
        if (c < 0) begin
            if (mag > (64'd1 << 31)) mag = 64'd1 << 31;
            return 32'(-longint'(mag));
        end
        if (mag > (64'd1 << 31) - 1) mag = (64'd1 << 31) - 1;
        return 32'(mag);
    endfunction

    function automatic t_normal predict_normal(input logic signed [CW-1:0] p[9]);
        longint ea[3], eb[3], ua[3], ub[3];
        t_normal n;
        for (int j = 0; j < 3; j++) begin
            ea[j] = longint'(p[j]) - longint'(p[6+j]);
            eb[j] = longint'(p[3+j]) - longint'(p[6+j]);
        end
        unit_edge(ea, ua);
        unit_edge(eb, ub);
        n.nx = round_q30(ua[1]*ub[2] - ua[2]*ub[1]);
        n.ny = round_q30(ua[2]*ub[0] - ua[0]*ub[2]);
        n.nz = round_q30(ua[0]*ub[1] - ua[1]*ub[0]);
        return n;
    endfunction

    // send one triangle request and queue its expected normal
    task automatic send_triangle(input logic signed [CW-1:0] p[9]);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_p0_x <= p[0]; i_p0_y <= p[1]; i_p0_z <= p[2];
        i_p1_x <= p[3]; i_p1_y <= p[4]; i_p1_z <= p[5];
        i_p2_x <= p[6]; i_p2_y <= p[7]; i_p2_z <= p[8];
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        normal_queue.push_back(predict_normal(p));
        sent++;
    endtask

    function automatic logic signed [CW-1:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 2000)) - 1000;
            2: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            default: return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(3)
                                              : 32'sh80000000 + $urandom_range(3);
        endcase
    endfunction

    // receiver stall and result check
    always @(posedge i_clk) begin
        t_normal e;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (normal_queue.size() == 0) begin
                    $display("%0t: unexpected result %h %h %h", $time,
                             o_normal_x, o_normal_y, o_normal_z);
                    errors++;
                end else begin
                    e = normal_queue.pop_front();
                    checked++;
                    if (o_normal_x !== e.nx) begin
                        $display("%0t: normal_x exp %h got %h", $time, e.nx, o_normal_x);
                        errors++;
                    end
                    if (o_normal_y !== e.ny) begin
                        $display("%0t: normal_y exp %h got %h", $time, e.ny, o_normal_y);
                        errors++;
                    end
                    if (o_normal_z !== e.nz) begin
                        $display("%0t: normal_z exp %h got %h", $time, e.nz, o_normal_z);
                        errors++;
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic test_directed();
        logic signed [CW-1:0] p[9];
        // zero-length edges, right angle, degenerate, extremes
        p = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                     send_triangle(p);
        p = '{5, 6, 7, 1, 2, 3, 5, 6, 7};                     send_triangle(p);
        p = '{1 << 16, 0, 0, 0, 1 << 16, 0, 0, 0, 0};         send_triangle(p);
        p = '{0, 1 << 16, 0, 1 << 16, 0, 0, 0, 0, 0};         send_triangle(p);
        p = '{2, 2, 2, 4, 4, 4, 0, 0, 0};                     send_triangle(p);
        p = '{1, 0, 0, -1, 0, 0, 0, 0, 0};                    send_triangle(p);
        p = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
              0, 32'sh80000000, 32'sh80000000, 32'sh80000000}; send_triangle(p);
        p = '{32'sh80000000, 0, 0, 0, 32'sh80000000, 0,
              32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};   send_triangle(p);
        p = '{-1, -1, -1, 1, 1, -1, 0, 0, 0};                 send_triangle(p);
        p = '{3, 0, 0, 0, 4, 0, 0, 0, 12};                    send_triangle(p);
        p = '{32'sh7fffffff, 1, 0, 1, 32'sh7fffffff, 0, 0, 0, 0}; send_triangle(p);
        p = '{-7, 3, 100000, 9, -2, -50000, 1, 1, 1};         send_triangle(p);
        p = '{32'shffffffff, 32'shffffffff, 32'shffffffff, 32'shffffffff,
              32'shffffffff, 32'shffffffff, 32'shffffffff, 32'shffffffff, 0}; send_triangle(p);
    endtask

    task automatic test_random(input int count);
        logic signed [CW-1:0] p[9];
        int mode, pick;
        for (int i = 0; i < count; i++) begin
            mode = $urandom_range(3);
            for (int j = 0; j < 9; j++) p[j] = rand_coord($urandom_range(9) < 8 ? mode : 0);
            pick = $urandom_range(19);
            if (pick == 0) for (int j = 0; j < 3; j++) p[j] = p[6+j];      // zero edge a
            if (pick == 1) for (int j = 0; j < 3; j++) p[3+j] = p[6+j];    // zero edge b
            if (pick == 2) for (int j = 0; j < 3; j++) p[3+j] = p[j];      // parallel edges
            send_triangle(p);
        end
    endtask

    // sender holds off until the pipeline has drained
    task automatic test_drain_pause();
        logic signed [CW-1:0] p[9];
        i_valid <= 1'b0;
        while (normal_queue.size() != 0) @(posedge i_clk);
        for (int j = 0; j < 9; j++) p[j] = rand_coord(2);
        send_triangle(p);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 27;
        recv_idle_pct = 88;
        test_directed();
        test_random(400);
        test_drain_pause();
        send_idle_pct = 88;
        recv_idle_pct = 27;
        test_random(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(700);
        i_valid <= 1'b0;
        while (normal_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("sent %0d triangles, checked %0d normals", sent, checked);
        $display("covered zero and parallel edges, extreme coordinates, mixed stalls");
        if (errors == 0 && normal_queue.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // run limit
    initial begin
        #8000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: triangle_normal_unit_edges_unit.f
+incdir+sv
sv/tneu_pkg.sv
sv/tneu_sqrt_cell.sv
sv/tneu_div_cell.sv
sv/triangle_normal_unit_edges_unit.sv
sv/tneu_checker.sv
sim/tb_triangle_normal_unit_edges_unit.sv
